// File: hw/rtl/sswm_pkg.sv
// Shared constants, types and the tangent table of the wheel speed mixer.
`default_nettype none
package sswm_pkg;

    localparam int SPD_W            = 16;
    localparam int ANG_W            = 8;
    localparam int DIM_W            = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int MAG_W            = SPD_W + 1;

    localparam int TAN_FRAC_BITS    = 8;
    localparam int FACTOR_FRAC_BITS = 14;

    localparam int Q_W       = FACTOR_FRAC_BITS + 2;
    localparam int TAN_W     = TAN_FRAC_BITS + 6;
    localparam int PROD_W    = TAN_W + DIM_W;
    localparam int RAD_FRAC  = 8;
    localparam int RAD_W     = 22;
    localparam int EXT_W     = PROD_W + RAD_FRAC;
    localparam int TAN_SHIFT = 16 - TAN_FRAC_BITS;
    localparam int TAN_HALF  = (1 << TAN_SHIFT) >> 1;
    localparam int INNER_SHR = (TAN_FRAC_BITS >= RAD_FRAC) ? TAN_FRAC_BITS - RAD_FRAC : 0;
    localparam int INNER_SHL = (TAN_FRAC_BITS >= RAD_FRAC) ? 0 : RAD_FRAC - TAN_FRAC_BITS;

    localparam int ANG_MAX   = 90;
    localparam int SPIN_DEG  = 15;
    localparam int BAND_DEG  = 5;
    localparam int TAN_DEPTH = 90;
    localparam int TAN_LAST  = TAN_DEPTH - 1;
    localparam int IDX_W     = 7;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam logic [Q_W-1:0] FAC_ONE  = Q_W'(1) << FACTOR_FRAC_BITS;
    localparam logic [Q_W-1:0] FAC_1P5  = Q_W'(3) << (FACTOR_FRAC_BITS - 1);
    localparam logic [Q_W-1:0] FAC_0P75 = Q_W'(3) << (FACTOR_FRAC_BITS - 2);
    localparam logic [Q_W-1:0] FAC_MAX  = '1;

    localparam logic [DIM_W-1:0] TRACK_RST = DIM_W'(100);
    localparam logic [DIM_W-1:0] WB_RST    = DIM_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIMPLE_MODE = 2'd0,
        REG_TRACK_WIDTH = 2'd1,
        REG_WHEELBASE   = 2'd2
    } cfg_reg_t;

    // tan of 0 to 89 degrees in Q6.16.
    localparam logic [21:0] TAN_Q16 [TAN_DEPTH] = '{
        22'd0, 22'd1144, 22'd2289, 22'd3435, 22'd4583, 22'd5734, 22'd6888, 22'd8047,
        22'd9210, 22'd10380, 22'd11556, 22'd12739, 22'd13930, 22'd15130, 22'd16340,
        22'd17560, 22'd18792, 22'd20036, 22'd21294, 22'd22566, 22'd23853, 22'd25157,
        22'd26478, 22'd27818, 22'd29179, 22'd30560, 22'd31964, 22'd33392, 22'd34846,
        22'd36327, 22'd37837, 22'd39378, 22'd40951, 22'd42560, 22'd44205, 22'd45889,
        22'd47615, 22'd49385, 22'd51202, 22'd53070, 22'd54991, 22'd56970, 22'd59009,
        22'd61113, 22'd63287, 22'd65536, 22'd67865, 22'd70279, 22'd72785, 22'd75391,
        22'd78103, 22'd80930, 22'd83882, 22'd86969, 22'd90203, 22'd93595, 22'd97161,
        22'd100917, 22'd104880, 22'd109070, 22'd113512, 22'd118230, 22'd123255,
        22'd128622, 22'd134369, 22'd140542, 22'd147196, 22'd154393, 22'd162207,
        22'd170727, 22'd180059, 22'd190330, 22'd201699, 22'd214359, 22'd228551,
        22'd244584, 22'd262851, 22'd283868, 22'd308323, 22'd337153, 22'd371673,
        22'd413778, 22'd466313, 22'd533748, 22'd623533, 22'd749080, 22'd937208,
        22'd1250501, 22'd1876705, 22'd3754555
    };

    function automatic logic [TAN_W-1:0] tan_fx(input logic [IDX_W-1:0] d);
        logic [22:0] v;
        v = {1'b0, TAN_Q16[d]} + 23'(TAN_HALF);
        return TAN_W'(v >> TAN_SHIFT);
    endfunction

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             s_neg;
        logic             flip_l;
        logic             flip_r;
        logic             div_en;
        logic             turn_right;
        logic [Q_W-1:0]   fac_l;
        logic [Q_W-1:0]   fac_r;
        logic             sat_o;
        logic             zero_i;
    } ctl_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [RAD_W-1:0] num_o;
        logic [RAD_W-1:0] num_i;
        logic [RAD_W-1:0] den;
    } q_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/sswm_front.sv
// Front end: configuration registers, angle classification and radius setup.
`default_nettype none
module sswm_front
    import sswm_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [SPD_W-1:0]     speed,
    input  wire logic signed [ANG_W-1:0]     steer_angle,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [DIM_W-1:0]            cfg_wdata,
    input  wire logic [CNT_W-1:0]            q_count,
    output logic                             push,
    output q_item_t                          push_item
);

    localparam logic signed [ANG_W-1:0] ANG_HI = ANG_W'(ANG_MAX);
    localparam logic signed [ANG_W-1:0] ANG_LO = -ANG_W'(ANG_MAX);

    logic                    simple_mode_reg, simple_mode_next;
    logic [DIM_W-1:0]        track_reg, track_next;
    logic [DIM_W-1:0]        wheelbase_reg, wheelbase_next;

    logic                    s1_valid_reg, s1_valid_next;
    logic signed [SPD_W-1:0] s1_speed_reg, s1_speed_next;
    logic [IDX_W-1:0]        s1_abs_reg, s1_abs_next;
    logic                    s1_pos_reg, s1_pos_next;
    logic                    s1_zero_reg, s1_zero_next;
    logic [TAN_W-1:0]        s1_tan_reg, s1_tan_next;

    logic                    s2_valid_reg, s2_valid_next;
    ctl_t                    s2_ctl_reg, s2_ctl_next;
    logic [PROD_W-1:0]       s2_prod_reg, s2_prod_next;

    logic                    accept;
    logic signed [ANG_W-1:0] ang_clamp;
    logic [IDX_W-1:0]        ang_abs;
    logic [IDX_W-1:0]        tan_idx;
    logic signed [MAG_W-1:0] sp_ext;
    logic [EXT_W-1:0]        prod_ext;
    logic [RAD_W-1:0]        inner;
    logic [RAD_W-1:0]        middle;
    logic [RAD_W-1:0]        num_o;
    logic [CNT_W:0]          pending;

    assign pending = {1'b0, q_count} + (CNT_W + 1)'(s1_valid_reg)
                   + (CNT_W + 1)'(s2_valid_reg);
    assign busy    = pending >= (CNT_W + 1)'(QDEPTH);
    assign accept  = start && !busy;

    always_comb
    begin
        simple_mode_next = simple_mode_reg;
        track_next       = track_reg;
        wheelbase_next   = wheelbase_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SIMPLE_MODE: simple_mode_next = cfg_wdata[0];
                REG_TRACK_WIDTH: track_next       = cfg_wdata;
                REG_WHEELBASE:   wheelbase_next   = cfg_wdata;
                default:         simple_mode_next = simple_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        if (steer_angle > ANG_HI)
        begin
            ang_clamp = ANG_HI;
        end
        else if (steer_angle < ANG_LO)
        begin
            ang_clamp = ANG_LO;
        end
        else
        begin
            ang_clamp = steer_angle;
        end
        ang_abs = ang_clamp[ANG_W-1] ? IDX_W'(-ang_clamp) : IDX_W'(ang_clamp);
        tan_idx = (ang_abs == '0) ? IDX_W'(TAN_LAST) : IDX_W'(ANG_MAX) - ang_abs;

        s1_valid_next = accept;
        s1_speed_next = speed;
        s1_abs_next   = ang_abs;
        s1_pos_next   = !ang_clamp[ANG_W-1] && (ang_abs != '0);
        s1_zero_next  = (ang_abs == '0);
        s1_tan_next   = tan_fx(tan_idx);
    end

    always_comb
    begin
        sp_ext = MAG_W'(s1_speed_reg);

        s2_valid_next          = s1_valid_reg;
        s2_prod_next           = PROD_W'(s1_tan_reg) * PROD_W'(wheelbase_reg);
        s2_ctl_next.mag        = s1_speed_reg[SPD_W-1] ? MAG_W'(-sp_ext) : MAG_W'(sp_ext);
        s2_ctl_next.s_neg      = s1_speed_reg[SPD_W-1];
        s2_ctl_next.flip_l     = 1'b0;
        s2_ctl_next.flip_r     = 1'b0;
        s2_ctl_next.div_en     = 1'b0;
        s2_ctl_next.turn_right = s1_pos_reg;
        s2_ctl_next.fac_l      = FAC_ONE;
        s2_ctl_next.fac_r      = FAC_ONE;
        s2_ctl_next.sat_o      = 1'b0;
        s2_ctl_next.zero_i     = 1'b0;

        if (!s1_zero_reg)
        begin
            if (simple_mode_reg)
            begin
                if (s1_abs_reg > IDX_W'(SPIN_DEG))
                begin
                    s2_ctl_next.fac_l  = FAC_1P5;
                    s2_ctl_next.fac_r  = FAC_1P5;
                    s2_ctl_next.flip_l = !s1_pos_reg;
                    s2_ctl_next.flip_r = s1_pos_reg;
                end
                else if (s1_abs_reg > IDX_W'(BAND_DEG))
                begin
                    s2_ctl_next.fac_l = s1_pos_reg ? FAC_1P5 : FAC_0P75;
                    s2_ctl_next.fac_r = s1_pos_reg ? FAC_0P75 : FAC_1P5;
                end
            end
            else
            begin
                s2_ctl_next.div_en = 1'b1;
            end
        end
    end

    always_comb
    begin
        prod_ext = EXT_W'(s2_prod_reg);
        inner    = RAD_W'((prod_ext << INNER_SHL) >> INNER_SHR);
        middle   = inner + (RAD_W'(track_reg >> 1) << RAD_FRAC);
        num_o    = inner + (RAD_W'(track_reg) << RAD_FRAC);

        push_item.ctl        = s2_ctl_reg;
        push_item.ctl.sat_o  = {2'b00, num_o} >= {middle, 2'b00};
        push_item.ctl.zero_i = (middle == '0);
        push_item.num_o      = num_o;
        push_item.num_i      = inner;
        push_item.den        = middle;
    end

    assign push = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simple_mode_reg <= 1'b0;
            track_reg       <= TRACK_RST;
            wheelbase_reg   <= WB_RST;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            simple_mode_reg <= simple_mode_next;
            track_reg       <= track_next;
            wheelbase_reg   <= wheelbase_next;
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_speed_reg <= s1_speed_next;
        s1_abs_reg   <= s1_abs_next;
        s1_pos_reg   <= s1_pos_next;
        s1_zero_reg  <= s1_zero_next;
        s1_tan_reg   <= s1_tan_next;
        s2_ctl_reg   <= s2_ctl_next;
        s2_prod_reg  <= s2_prod_next;
    end

`ifndef ASSERT_OFF
    a_accept_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 push)
        else $error("Accepted item did not reach the queue two cycles later.");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/sswm_queue.sv
// Short queue that decouples the front end from the back end.
`default_nettype none
module sswm_queue
    import sswm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire q_item_t          push_item,
    output logic                  valid,
    output q_item_t               item,
    output logic [CNT_W-1:0]      count
);

    q_item_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign valid = (count_reg != '0);
    assign pop   = valid;
    assign item  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(QDEPTH)))
        else $error("Item pushed into a full queue.");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/sswm_div.sv
// Pipelined restoring divider that yields one quotient bit per stage.
`default_nettype none
module sswm_div
    import sswm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [RAD_W-1:0] num,
    input  wire logic [RAD_W-1:0] den,
    output logic [Q_W-1:0]        quo
);

    logic [RAD_W-1:0] rem_reg [Q_W];
    logic [RAD_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   low_next [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];
    logic [RAD_W-1:0] den_reg [Q_W];
    logic [RAD_W-1:0] den_next [Q_W];

    logic [RAD_W-1:0] rem_in [Q_W];
    logic [Q_W-1:0]   low_in [Q_W];
    logic [Q_W-1:0]   quo_in [Q_W];
    logic [RAD_W-1:0] den_in [Q_W];
    logic [RAD_W:0]   trial [Q_W];

    always_comb
    begin
        rem_in[0] = num >> 2;
        low_in[0] = {num[1:0], FACTOR_FRAC_BITS'(0)};
        quo_in[0] = '0;
        den_in[0] = den;
        for (int i = 1; i < Q_W; i++)
        begin
            rem_in[i] = rem_reg[i-1];
            low_in[i] = low_reg[i-1];
            quo_in[i] = quo_reg[i-1];
            den_in[i] = den_reg[i-1];
        end
        for (int i = 0; i < Q_W; i++)
        begin
            trial[i] = {rem_in[i], low_in[i][Q_W-1]};
            if (trial[i] >= {1'b0, den_in[i]})
            begin
                rem_next[i] = RAD_W'(trial[i] - {1'b0, den_in[i]});
                quo_next[i] = {quo_in[i][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][RAD_W-1:0];
                quo_next[i] = {quo_in[i][Q_W-2:0], 1'b0};
            end
            low_next[i] = low_in[i] << 1;
            den_next[i] = den_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            rem_reg[i] <= rem_next[i];
            low_reg[i] <= low_next[i];
            quo_reg[i] <= quo_next[i];
            den_reg[i] <= den_next[i];
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/sswm_back.sv
// Back end: factor division, speed scaling and output saturation.
`default_nettype none
module sswm_back
    import sswm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire q_item_t           item,
    output logic                   done,
    output logic signed [SPD_W-1:0] left_speed,
    output logic signed [SPD_W-1:0] right_speed
);

    localparam int PRD_W    = MAG_W + Q_W;
    localparam int SCL_W    = PRD_W - FACTOR_FRAC_BITS;
    localparam int BACK_LAT = Q_W + 2;
    localparam int SPD_POS_LIM = (1 << (SPD_W - 1)) - 1;
    localparam int SPD_NEG_LIM = 1 << (SPD_W - 1);
    localparam logic signed [SPD_W-1:0] SPD_MAX = SPD_W'(SPD_POS_LIM);
    localparam logic signed [SPD_W-1:0] SPD_MIN = SPD_W'(SPD_NEG_LIM);

    function automatic logic signed [SPD_W-1:0] sat_spd(input logic [SCL_W-1:0] pm,
                                                        input logic neg);
        logic signed [SPD_W-1:0] r;
        if (neg)
        begin
            r = (pm > SCL_W'(SPD_NEG_LIM)) ? SPD_MIN : SPD_W'(SCL_W'(0) - pm);
        end
        else
        begin
            r = (pm > SCL_W'(SPD_POS_LIM)) ? SPD_MAX : SPD_W'(pm);
        end
        return r;
    endfunction

    logic                     vld_reg [Q_W];
    logic                     vld_next [Q_W];
    ctl_t                     ctl_reg [Q_W];
    ctl_t                     ctl_next [Q_W];

    logic                     vm_reg, vm_next;
    logic [PRD_W-1:0]         prod_l_reg, prod_l_next;
    logic [PRD_W-1:0]         prod_r_reg, prod_r_next;
    logic                     neg_l_reg, neg_l_next;
    logic                     neg_r_reg, neg_r_next;

    logic                     done_reg, done_next;
    logic signed [SPD_W-1:0]  left_reg, left_next;
    logic signed [SPD_W-1:0]  right_reg, right_next;

    logic [Q_W-1:0]           quo_o;
    logic [Q_W-1:0]           quo_i;
    logic [Q_W-1:0]           fac_o;
    logic [Q_W-1:0]           fac_i;
    logic [Q_W-1:0]           fac_l;
    logic [Q_W-1:0]           fac_r;
    ctl_t                     ctl_end;

    sswm_div u_div_outer
    (
        .clk (clk),
        .num (item.num_o),
        .den (item.den),
        .quo (quo_o)
    );

    sswm_div u_div_inner
    (
        .clk (clk),
        .num (item.num_i),
        .den (item.den),
        .quo (quo_i)
    );

    always_comb
    begin
        vld_next[0] = item_valid;
        ctl_next[0] = item.ctl;
        for (int i = 1; i < Q_W; i++)
        begin
            vld_next[i] = vld_reg[i-1];
            ctl_next[i] = ctl_reg[i-1];
        end
    end

    always_comb
    begin
        ctl_end = ctl_reg[Q_W-1];
        fac_o   = ctl_end.sat_o ? FAC_MAX : quo_o;
        fac_i   = ctl_end.zero_i ? '0 : quo_i;
        if (ctl_end.div_en)
        begin
            fac_l = ctl_end.turn_right ? fac_o : fac_i;
            fac_r = ctl_end.turn_right ? fac_i : fac_o;
        end
        else
        begin
            fac_l = ctl_end.fac_l;
            fac_r = ctl_end.fac_r;
        end
        vm_next     = vld_reg[Q_W-1];
        prod_l_next = PRD_W'(ctl_end.mag) * PRD_W'(fac_l);
        prod_r_next = PRD_W'(ctl_end.mag) * PRD_W'(fac_r);
        neg_l_next  = ctl_end.s_neg ^ ctl_end.flip_l;
        neg_r_next  = ctl_end.s_neg ^ ctl_end.flip_r;
    end

    always_comb
    begin
        done_next  = vm_reg;
        left_next  = sat_spd(SCL_W'(prod_l_reg >> FACTOR_FRAC_BITS), neg_l_reg);
        right_next = sat_spd(SCL_W'(prod_r_reg >> FACTOR_FRAC_BITS), neg_r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Q_W; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < Q_W; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
            vm_reg   <= vm_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            ctl_reg[i] <= ctl_next[i];
        end
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        neg_l_reg  <= neg_l_next;
        neg_r_reg  <= neg_r_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    assign done        = done_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;

`ifndef ASSERT_OFF
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> ##(BACK_LAT) done)
        else $error("Item taken from the queue did not complete on schedule.");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/skid_steer_wheel_speed_mixer_unit.sv
// Top level of the skid-steer wheel speed mixer.
//
//   Channel   Handshake            Payload
//   command   start / busy         speed, steer_angle
//   result    done (strobe)        left_speed, right_speed
//   config    cfg_we               cfg_index, cfg_wdata
//
// A new item can be taken every cycle while busy is low; each one passes the front
// end, the queue and the back end in order before it appears on the result ports.
// The divider in the back end resolves one quotient bit per stage.
// Reset is asynchronous and active low; it restores the register defaults
// and empties every stage. Busy would rise once the front end and queue held four
// items, but the back end drains one item every cycle, so at most three are ever
// held and busy stays low.
`default_nettype none
module skid_steer_wheel_speed_mixer_unit
    import sswm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [SPD_W-1:0] speed,
    input  wire logic signed [ANG_W-1:0] steer_angle,
    output logic                         done,
    output logic signed [SPD_W-1:0]      left_speed,
    output logic signed [SPD_W-1:0]      right_speed,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [DIM_W-1:0]        cfg_wdata
);

    logic             push;
    q_item_t          push_item;
    logic             q_valid;
    q_item_t          q_item;
    logic [CNT_W-1:0] q_count;

    sswm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .speed       (speed),
        .steer_angle (steer_angle),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_count     (q_count),
        .push        (push),
        .push_item   (push_item)
    );

    sswm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .valid     (q_valid),
        .item      (q_item),
        .count     (q_count)
    );

    sswm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item        (q_item),
        .done        (done),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

endmodule
`default_nettype wire

// File: tb/sv/skid_steer_wheel_speed_mixer_unit_tb.sv
// Self-checking testbench for the skid-steer wheel speed mixer: directed rows, then random phases.
`timescale 1ns / 1ps
module skid_steer_wheel_speed_mixer_unit_tb;
    import sswm_pkg::*;

    localparam int TAN_SH = 8;
    localparam int FAC_SH = 14;
    localparam longint FAC_LIMIT = (64'd1 << (FAC_SH + 2)) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int ROWS = 25;

    typedef struct packed {
        logic signed [SPD_W-1:0] left_w;
        logic signed [SPD_W-1:0] right_w;
    } wheel_pair_t;

    typedef struct packed {
        logic                    mode;
        logic [DIM_W-1:0]        track;
        logic [DIM_W-1:0]        base;
        logic signed [SPD_W-1:0] spd;
        logic signed [ANG_W-1:0] ang;
        logic                    fixed;
        logic signed [SPD_W-1:0] l;
        logic signed [SPD_W-1:0] r;
    } steer_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [SPD_W-1:0] speed;
    logic signed [ANG_W-1:0] steer_angle;
    logic done;
    logic signed [SPD_W-1:0] left_speed;
    logic signed [SPD_W-1:0] right_speed;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_wdata;

    bit mode_simple;
    int track_mm;
    int base_mm;
    int wheel_errors;
    wheel_pair_t pending_wheels [$];

    longint tan_deg_q16 [0:89] = '{
        0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
        11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
        23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
        37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
        54991, 56970, 59009, 61113, 63287, 65536, 67865, 70279, 72785, 75391,
        78103, 80930, 83882, 86969, 90203, 93595, 97161, 100917, 104880, 109070,
        113512, 118230, 123255, 128622, 134369, 140542, 147196, 154393, 162207, 170727,
        180059, 190330, 201699, 214359, 228551, 244584, 262851, 283868, 308323, 337153,
        371673, 413778, 466313, 533748, 623533, 749080, 937208, 1250501, 1876705, 3754555
    };

    steer_row_t steer_rows [ROWS] = '{
        '{0, 100, 100, 1000, 0, 1, 1000, 1000},
        '{0, 100, 100, -32768, 0, 1, -32768, -32768},
        '{0, 100, 100, 32767, 0, 1, 32767, 32767},
        '{0, 100, 100, 1000, 90, 1, 2000, 0},
        '{0, 100, 100, 1000, -90, 1, 0, 2000},
        '{0, 100, 100, 32767, 127, 1, 32767, 0},
        '{0, 100, 100, -32768, -128, 1, 0, -32768},
        '{0, 100, 100, 5000, 45, 0, 0, 0},
        '{0, 100, 100, -12345, 1, 0, 0, 0},
        '{0, 100, 100, 777, -89, 0, 0, 0},
        '{0, 100, 100, 32767, 91, 0, 0, 0},
        '{1, 100, 100, 1234, 0, 1, 1234, 1234},
        '{1, 100, 100, 1000, 16, 1, 1500, -1500},
        '{1, 100, 100, 1000, -16, 1, -1500, 1500},
        '{1, 100, 100, 1000, 15, 1, 1500, 750},
        '{1, 100, 100, 1000, -6, 1, 750, 1500},
        '{1, 100, 100, 1000, 5, 1, 1000, 1000},
        '{1, 100, 100, -1001, -5, 1, -1001, -1001},
        '{1, 100, 100, 32767, 90, 1, 32767, -32768},
        '{1, 100, 100, -3, 10, 1, -4, -2},
        '{0, 1, 100, 1000, 90, 1, 3999, 0},
        '{0, 0, 0, -500, -30, 1, 0, -1999},
        '{0, 255, 255, 32767, 1, 0, 0, 0},
        '{0, 255, 255, -32768, -45, 0, 0, 0},
        '{0, 255, 255, 100, -91, 0, 0, 0}
    };

    skid_steer_wheel_speed_mixer_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .speed(speed),
        .steer_angle(steer_angle),
        .done(done),
        .left_speed(left_speed),
        .right_speed(right_speed),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("skid_steer_wheel_speed_mixer_unit_tb: errors");
        $finish;
    end

    function automatic logic signed [SPD_W-1:0] clip16(input longint v);
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return v[SPD_W-1:0];
    endfunction

    function automatic longint fac_ratio(input longint num, input longint den);
        longint q;
        q = (num << FAC_SH) / den;
        return (q > FAC_LIMIT) ? FAC_LIMIT : q;
    endfunction

    // Magnitude is scaled so the product truncates toward zero.
    function automatic logic signed [SPD_W-1:0] scale16(input longint s, input longint fac);
        longint mag;
        longint p;
        mag = (s < 0) ? -s : s;
        p = (mag * fac) >> FAC_SH;
        return clip16((s < 0) ? -p : p);
    endfunction

    function automatic wheel_pair_t mix_wheels(input logic signed [SPD_W-1:0] spd,
                                               input logic signed [ANG_W-1:0] ang);
        longint s;
        longint a;
        longint spin_val;
        longint lag_val;
        longint d;
        longint t;
        longint inner;
        longint middle;
        longint fo_q;
        longint fi_q;
        logic signed [SPD_W-1:0] fo;
        logic signed [SPD_W-1:0] fi;
        wheel_pair_t w;
        s = spd;
        a = ang;
        if (a > 90)
        begin
            a = 90;
        end
        if (a < -90)
        begin
            a = -90;
        end
        if (a == 0)
        begin
            w.left_w = clip16(s);
            w.right_w = w.left_w;
        end
        else if (mode_simple)
        begin
            spin_val = (3 * s) / 2;
            lag_val = (3 * s) / 4;
            if (a > 15)
            begin
                w.left_w = clip16(spin_val);
                w.right_w = clip16(-spin_val);
            end
            else if (a < -15)
            begin
                w.left_w = clip16(-spin_val);
                w.right_w = clip16(spin_val);
            end
            else if (a > 5)
            begin
                w.left_w = clip16(spin_val);
                w.right_w = clip16(lag_val);
            end
            else if (a < -5)
            begin
                w.left_w = clip16(lag_val);
                w.right_w = clip16(spin_val);
            end
            else
            begin
                w.left_w = clip16(s);
                w.right_w = w.left_w;
            end
        end
        else
        begin
            d = 90 - ((a < 0) ? -a : a);
            t = (tan_deg_q16[d] + (1 << (16 - TAN_SH - 1))) >> (16 - TAN_SH);
            inner = t * base_mm;
            middle = inner + ((track_mm >> 1) << 8);
            if (middle == 0)
            begin
                fo_q = FAC_LIMIT;
                fi_q = 0;
            end
            else
            begin
                fo_q = fac_ratio(inner + (track_mm << 8), middle);
                fi_q = fac_ratio(inner, middle);
            end
            fo = scale16(s, fo_q);
            fi = scale16(s, fi_q);
            w.left_w = (a > 0) ? fo : fi;
            w.right_w = (a > 0) ? fi : fo;
        end
        return w;
    endfunction

    always @(posedge clk)
    begin
        wheel_pair_t want;
        if (rst_n && done)
        begin
            if (pending_wheels.size() == 0)
            begin
                wheel_errors++;
                if (wheel_errors <= 10)
                begin
                    $display("unexpected result: left=%0d right=%0d", left_speed, right_speed);
                end
            end
            else
            begin
                want = pending_wheels.pop_front();
                if (left_speed !== want.left_w || right_speed !== want.right_w)
                begin
                    wheel_errors++;
                    if (wheel_errors <= 10)
                    begin
                        $display("mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                                 want.left_w, want.right_w, left_speed, right_speed);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_SIMPLE_MODE: mode_simple = data[0];
            REG_TRACK_WIDTH: track_mm = data;
            REG_WHEELBASE: base_mm = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input bit simple, input int track, input int base);
        write_reg(REG_SIMPLE_MODE, {7'($urandom), simple});
        write_reg(REG_TRACK_WIDTH, track[DIM_W-1:0]);
        write_reg(REG_WHEELBASE, base[DIM_W-1:0]);
        write_reg(REG_SPARE, 8'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_wheels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_item(input logic signed [SPD_W-1:0] spd,
                             input logic signed [ANG_W-1:0] ang,
                             input bit fixed, input wheel_pair_t typed, input bit may_idle);
        start <= 1'b1;
        speed <= spd;
        steer_angle <= ang;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_wheels.push_back(fixed ? typed : mix_wheels(spd, ang));
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    function automatic logic signed [ANG_W-1:0] pick_angle();
        int edge_angles [15] = '{0, 1, -1, 5, -5, 6, -6, 15, -15, 16, -16, 89, -89, 90, -90};
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
        begin
            return ANG_W'(int'($urandom_range(0, 180)) - 90);
        end
        else if (r <= 7)
        begin
            return ANG_W'(edge_angles[$urandom_range(0, 14)]);
        end
        return ANG_W'($urandom);
    endfunction

    function automatic logic signed [SPD_W-1:0] pick_speed();
        int edge_speeds [5] = '{-32768, 32767, 0, -1, 1};
        if ($urandom_range(0, 7) == 0)
        begin
            return SPD_W'(edge_speeds[$urandom_range(0, 4)]);
        end
        return SPD_W'($urandom);
    endfunction

    initial
    begin
        wheel_pair_t typed;
        int track;
        int base;
        bit may_idle;
        rst_n = 1'b0;
        start = 1'b0;
        speed = '0;
        steer_angle = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        wheel_errors = 0;
        mode_simple = 1'b0;
        track_mm = 100;
        base_mm = 100;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steer_rows[i])
        begin
            if (steer_rows[i].mode != mode_simple || steer_rows[i].track != track_mm
                || steer_rows[i].base != base_mm)
            begin
                settle();
                apply_setup(steer_rows[i].mode, steer_rows[i].track, steer_rows[i].base);
            end
            typed.left_w = steer_rows[i].l;
            typed.right_w = steer_rows[i].r;
            push_item(steer_rows[i].spd, steer_rows[i].ang, steer_rows[i].fixed, typed, 1'b1);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: track = 0;
                1: track = 1;
                2: track = 2;
                3: track = 255;
                default: track = $urandom_range(1, 255);
            endcase
            case ($urandom_range(0, 3))
                0: base = 0;
                1: base = 255;
                default: base = $urandom_range(0, 255);
            endcase
            apply_setup((p == 0) ? 1'b1 : ((p == 1) ? 1'b0 : 1'($urandom)), track, base);
            may_idle = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS)
            begin
                push_item(pick_speed(), pick_angle(), 1'b0, typed, may_idle);
            end
        end

        start <= 1'b0;
        while (pending_wheels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (wheel_errors == 0)
        begin
            $display("skid_steer_wheel_speed_mixer_unit_tb: clean");
        end
        else
        begin
            $display("skid_steer_wheel_speed_mixer_unit_tb: errors");
        end
        $finish;
    end

endmodule

// File: skid_steer_wheel_speed_mixer_unit.f
hw/rtl/sswm_pkg.sv
hw/rtl/sswm_front.sv
hw/rtl/sswm_queue.sv
hw/rtl/sswm_div.sv
hw/rtl/sswm_back.sv
hw/rtl/skid_steer_wheel_speed_mixer_unit.sv
tb/sv/skid_steer_wheel_speed_mixer_unit_tb.sv
